>>> rtl/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// double_ended_queue_defines.svh
// Assertion macros used by the deque back end (dq_back).
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the deque front end, back end and queues.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int ELEM_W = 32;

  // request action codes on the input port
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DUMP       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [ELEM_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0]  element;
    logic [1:0]                status;
    logic                      last;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

endpackage

>>> rtl/dq_fifo.sv
// ----------------------------------------------------------------------------
// dq_fifo
// Two-entry register queue; decouples the deque stages.
// ----------------------------------------------------------------------------
module dq_fifo
  import dq_pkg::*;
#(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

>>> rtl/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Request decoder: maps action codes to commands, drops undefined codes.
// ----------------------------------------------------------------------------
module dq_front
  import dq_pkg::*;
(
  input  logic                      in_push,
  input  logic [2:0]                in_action,
  input  logic signed [ELEM_W-1:0]  in_value,
  input  logic                      cmdq_full,
  output logic                      cmd_push,
  output cmd_t                      cmd
);

  logic known;

  always_comb begin
    known     = 1'b1;
    cmd.value = in_value;
    cmd.op    = OP_PUSH_FRONT;
    case (in_action)
      ACT_PUSH_FRONT: cmd.op = OP_PUSH_FRONT;
      ACT_PUSH_BACK:  cmd.op = OP_PUSH_BACK;
      ACT_POP_FRONT:  cmd.op = OP_POP_FRONT;
      ACT_POP_BACK:   cmd.op = OP_POP_BACK;
      ACT_DUMP:       cmd.op = OP_DUMP;
      default:        known  = 1'b0;  // undefined code: accepted, no effect
    endcase
  end

  assign cmd_push = in_push && !cmdq_full && known;

endmodule

>>> rtl/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Executes commands on the circular slot store and emits result items.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_back
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic outq_full,
  output logic res_push,
  output res_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_WR} state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;

  logic [ELEM_W-1:0]   mem [DEPTH];
  logic [ELEM_W-1:0]   rd_data_r;
  logic                we;
  logic [AW-1:0]       waddr;

  logic [AW-1:0]       front_dec, front_inc, rp_inc, back_idx;
  logic [SW-1:0]       back_sum;
  logic                is_full, is_empty, dump_last;

  assign is_full   = (occ_r == CW'(DEPTH));
  assign is_empty  = (occ_r == '0);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign rp_inc    = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
  assign back_sum  = SW'(front_r) + SW'(occ_r);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                              : AW'(back_sum);
  assign dump_last = (rem_r == CW'(1));

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    occ_nxt     = occ_r;
    rp_nxt      = rp_r;
    rem_nxt     = rem_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res.element = '0;
    res.status  = ST_OK;
    res.last    = 1'b1;
    we          = 1'b0;
    waddr       = front_dec;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !outq_full) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          case (cmd.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = front_dec;
                front_nxt = front_dec;
                occ_nxt   = occ_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = back_idx;
                occ_nxt = occ_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                front_nxt = front_inc;
                occ_nxt   = occ_r - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                occ_nxt = occ_r - CW'(1);
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                res_push  = 1'b0;
                rp_nxt    = front_r;
                rem_nxt   = occ_r;
                state_nxt = S_RD;
              end
            end
            default: res_push = 1'b0;
          endcase
        end
      end
      S_RD: begin
        // only this block fills the result queue, so room seen here holds
        if (!outq_full) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        res_push    = 1'b1;
        res.element = rd_data_r;
        res.last    = dump_last;
        rem_nxt     = rem_r - CW'(1);
        rp_nxt      = rp_inc;
        state_nxt   = dump_last ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
    rp_r  <= rp_nxt;
    rem_r <= rem_nxt;
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cmd.value;
    end
    rd_data_r <= mem[rp_r];
  end

  `DQ_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CW'(DEPTH), "occupancy over depth")
  `DQ_ASSERT_IMPL(a_res_room, clk, rst_n, res_push, !outq_full, "result pushed into full queue")
  `DQ_ASSERT_IMPL(a_dump_rem, clk, rst_n, state_r != S_IDLE, rem_r != '0, "dump walk with nothing left")
  `DQ_ASSERT_NEXT(a_push_grow, clk, rst_n, we, occ_r == $past(occ_r) + CW'(1), "push did not grow queue")

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a circular slot store.
// ----------------------------------------------------------------------------
//   channel   ports                                   handshake
//   request   in_action, in_value                     in_push / in_full
//   result    out_element, out_status, out_last       out_pop / out_empty
//
// Flow: the back end executes a push or pop in the cycle that it takes the
// command; an accepted request is registered in the command queue and its
// result in the result queue before it reaches the result ports. A dump
// walks the slot store element by element, alternating a read state and a
// write state (registered read port of the store) and waiting while the
// result queue is full; during the walk no other request is executed.
// Requests keep entering until the two-entry command queue is full. Reset
// (synchronous, rst_n low) empties the deque and both queues; the slot store
// holds no reset value. A stalled result side backs up into the command queue and then raises in_full.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request side
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [2:0]                in_action,
  input  logic signed [ELEM_W-1:0]  in_value,
  // result side
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [ELEM_W-1:0]  out_element,
  output logic [1:0]                out_status,
  output logic                      out_last
);

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  // front end: classify the request, drop undefined actions
  dq_front u_front (
    .in_push   (in_push),
    .in_action (in_action),
    .in_value  (in_value),
    .cmdq_full (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // the request is taken whenever the command queue has room, even if dropped
  assign in_full = cmd_full;

  dq_fifo #(.W(CMD_W)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // back end: owns the slot store, front index and occupancy
  dq_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .outq_full (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue lets the back end run ahead of a stalled consumer
  dq_fifo #(.W(RES_W)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_element = res_out.element;
  assign out_status  = res_out.status;
  assign out_last    = res_out.last;

endmodule

>>> tb/sv/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded deque. A request queue filled up front
// feeds a clocked driver; each accepted request runs through a local deque
// model that queues the expected status or dump items, and a clocked monitor
// checks every popped result against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int DQ_DEPTH     = 64;
  localparam int RANDOM_ITEMS = 420;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 200;   // extra wait after all expected items have arrived

  // codes outside the defined action set; the block must drop them silently
  localparam logic [2:0] ACT_RSVD_5 = 3'd5;
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  typedef struct {
    logic [2:0]               action;
    logic signed [ELEM_W-1:0] value;
  } request_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports; the inputs are known from time zero
  logic                     in_push   = 1'b0;
  logic                     in_full;
  logic [2:0]               in_action = ACT_PUSH_FRONT;
  logic signed [ELEM_W-1:0] in_value  = '0;
  logic                     out_empty;
  logic                     out_pop   = 1'b0;
  logic signed [ELEM_W-1:0] out_element;
  logic [1:0]               out_status;
  logic                     out_last;

  double_ended_queue #(
    .DEPTH (DQ_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_action   (in_action),
    .in_value    (in_value),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_element (out_element),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  // --------------------------------------------------------------------------
  // Local deque model. Mirrors the circular store: head_slot wraps at 6 bits,
  // which matches DEPTH = 64.
  // --------------------------------------------------------------------------
  logic signed [ELEM_W-1:0] deque_slots [DQ_DEPTH];
  logic [5:0]               head_slot  = '0;
  logic [6:0]               fill_level = '0;

  res_t     expected_results [$];
  request_t request_queue [$];

  int n_errors       = 0;
  int n_accepted     = 0;
  int n_results      = 0;
  int n_full_status  = 0;
  int n_empty_status = 0;
  int n_dumps        = 0;
  int longest_dump   = 0;
  int gen_level      = 0;  // occupancy as seen while building stimulus

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    n_errors++;
  endtask

  task automatic expect_status(input logic [1:0] st);
    res_t r;
    r.element = '0;
    r.status  = st;
    r.last    = 1'b1;
    expected_results.push_back(r);
    if (st == ST_FULL)  n_full_status++;
    if (st == ST_EMPTY) n_empty_status++;
  endtask

  task automatic apply_request(input logic [2:0] act, input logic signed [ELEM_W-1:0] val);
    res_t       r;
    logic [5:0] idx;
    case (act)
      ACT_PUSH_FRONT: begin
        if (fill_level == DQ_DEPTH) begin
          expect_status(ST_FULL);
        end else begin
          head_slot = head_slot - 1'b1;
          deque_slots[head_slot] = val;
          fill_level++;
          expect_status(ST_OK);
        end
      end
      ACT_PUSH_BACK: begin
        if (fill_level == DQ_DEPTH) begin
          expect_status(ST_FULL);
        end else begin
          idx = head_slot + fill_level[5:0];
          deque_slots[idx] = val;
          fill_level++;
          expect_status(ST_OK);
        end
      end
      ACT_POP_FRONT: begin
        if (fill_level == 0) begin
          expect_status(ST_EMPTY);
        end else begin
          head_slot = head_slot + 1'b1;
          fill_level--;
          expect_status(ST_OK);
        end
      end
      ACT_POP_BACK: begin
        if (fill_level == 0) begin
          expect_status(ST_EMPTY);
        end else begin
          fill_level--;
          expect_status(ST_OK);
        end
      end
      ACT_DUMP: begin
        n_dumps++;
        if (fill_level == 0) begin
          expect_status(ST_EMPTY);
        end else begin
          // front to back, last mark on the final element
          for (int k = 0; k < fill_level; k++) begin
            idx       = head_slot + k[5:0];
            r.element = deque_slots[idx];
            r.status  = ST_OK;
            r.last    = (k == fill_level - 1);
            expected_results.push_back(r);
          end
          if (fill_level > longest_dump) longest_dump = fill_level;
        end
      end
      default: ;  // reserved codes: no result, no state change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building. gen_level tracks occupancy so that fill and drain
  // runs know when the deque is full or empty.
  // --------------------------------------------------------------------------
  task automatic add_item(input logic [2:0] act, input logic signed [ELEM_W-1:0] val);
    request_t q;
    q.action = act;
    q.value  = val;
    request_queue.push_back(q);
    if ((act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && gen_level < DQ_DEPTH)
      gen_level++;
    else if ((act == ACT_POP_FRONT || act == ACT_POP_BACK) && gen_level > 0)
      gen_level--;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  function automatic logic [2:0] pick_reserved();
    case ($urandom_range(0, 2))
      0:       return ACT_RSVD_5;
      1:       return ACT_RSVD_6;
      default: return ACT_RSVD_7;
    endcase
  endfunction

  task automatic build_stimulus();
    int       start;
    int       burst;
    int       roll;
    // directed: empty cases, extreme values, front wrap, reserved codes
    add_item(ACT_DUMP,      '0);           // dump of an empty deque
    add_item(ACT_POP_FRONT, '0);           // pop on empty
    add_item(ACT_POP_BACK,  '0);
    add_item(ACT_PUSH_FRONT, 32'sh7fff_ffff);  // head wraps below slot 0
    add_item(ACT_PUSH_BACK,  32'sh8000_0000);
    add_item(ACT_PUSH_FRONT, -32'sd1);
    add_item(ACT_PUSH_BACK,  '0);
    add_item(ACT_PUSH_FRONT, 32'sh5555_5555);
    add_item(ACT_PUSH_BACK,  32'shaaaa_aaaa);
    add_item(ACT_DUMP,       $urandom);
    add_item(ACT_RSVD_5,     $urandom);
    add_item(ACT_RSVD_6,     $urandom);
    add_item(ACT_RSVD_7,     $urandom);
    add_item(ACT_POP_FRONT,  $urandom);
    add_item(ACT_POP_BACK,   $urandom);
    add_item(ACT_DUMP,       '0);
    repeat (4) add_item(pick_pop(), '0);   // down to empty
    add_item(ACT_POP_FRONT,  '0);
    add_item(ACT_DUMP,       '0);

    // random part, built from episodes
    start = request_queue.size();
    while (request_queue.size() - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        // fill to the top, then refused pushes and a full-length dump
        while (gen_level < DQ_DEPTH) add_item(pick_push(), pick_value());
        repeat ($urandom_range(1, 2)) add_item(pick_push(), pick_value());
        add_item(ACT_DUMP, $urandom);
      end else if (roll == 2) begin
        // drain to empty, then refused pops
        while (gen_level > 0) add_item(pick_pop(), $urandom);
        repeat ($urandom_range(1, 2)) add_item(pick_pop(), $urandom);
        add_item(ACT_DUMP, $urandom);
      end else begin
        // mixed burst
        burst = $urandom_range(10, 30);
        repeat (burst) begin
          roll = $urandom_range(0, 19);
          if (roll < 9)       add_item(pick_push(), pick_value());
          else if (roll < 16) add_item(pick_pop(), $urandom);
          else if (roll < 19) add_item(ACT_DUMP, $urandom);
          else                add_item(pick_reserved(), $urandom);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver. Each item draws its own gap; a calm spell drops the
  // gaps so back-to-back runs also happen.
  // --------------------------------------------------------------------------
  int in_gap  = 0;
  bit in_calm = 1'b0;

  always @(posedge clk) begin : request_driver
    request_t nxt;
    bit       take;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_gap  = 0;
    end else begin
      take = in_push && !in_full;
      if (take) begin
        apply_request(in_action, in_value);
        n_accepted++;
      end
      if (in_push && !take) begin
        // held until the block has room
      end else if (in_gap != 0) begin
        in_push <= 1'b0;
        in_gap--;
      end else if (request_queue.size() != 0) begin
        nxt = request_queue.pop_front();
        in_action <= nxt.action;
        in_value  <= nxt.value;
        in_push   <= 1'b1;
        if ($urandom_range(0, 23) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 15);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. After each item out_pop comes back after a drawn wait;
  // every popped item is checked field by field.
  // --------------------------------------------------------------------------
  int  out_wait = 0;
  bit  out_calm = 1'b0;

  always @(posedge clk) begin : result_monitor
    res_t want;
    bit   got;
    if (!rst_n) begin
      out_pop <= 1'b0;
      out_wait = 0;
    end else begin
      got = out_pop && !out_empty;
      if (got) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item: element=%0d status=%0d last=%0b",
                                    out_element, out_status, out_last));
        end else begin
          want = expected_results.pop_front();
          if (out_element !== want.element)
            report_mismatch($sformatf("item %0d element %0d, want %0d",
                                      n_results, out_element, want.element));
          if (out_status !== want.status)
            report_mismatch($sformatf("item %0d status %0d, want %0d",
                                      n_results, out_status, want.status));
          if (out_last !== want.last)
            report_mismatch($sformatf("item %0d last %0b, want %0b",
                                      n_results, out_last, want.last));
        end
        if ($urandom_range(0, 23) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 15);
        out_pop <= (out_wait == 0);
      end else if (!out_pop) begin
        if (out_wait == 0) out_pop <= 1'b1;
        else out_wait--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with nothing moving on either side ends the run.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing: build stimulus, release reset, wait for everything to drain.
  // --------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (request_queue.size() != 0 || in_push || expected_results.size() != 0)
      @(posedge clk);
    // reserved codes at the tail produce nothing; give the pipe time anyway
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected items never arrived",
                                expected_results.size()));
    $display("covered %0d requests, %0d result items, %0d dumps (longest %0d)",
             n_accepted, n_results, n_dumps, longest_dump);
    $display("refused pushes on full: %0d, pops/dumps on empty: %0d, mismatches: %0d",
             n_full_status, n_empty_status, n_errors);
    if (n_errors == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
